>>> rtl/pair_matching_unranker_macros.svh
// Assertion macros for the pair matching unranker.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef PAIR_MATCHING_UNRANKER_MACROS_SVH
`define PAIR_MATCHING_UNRANKER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PMU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmu check failed");

// Next-cycle implication, disabled while reset is low
`define PMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmu check failed");

`endif

>>> rtl/pmu_pkg.sv
// Shared types, field widths and the double factorial table for the
// pair matching unranker. No dependencies.
package pmu_pkg;

    localparam int N_W        = 4;   // set size register
    localparam int COMB_W     = 7;   // combination index
    localparam int PAIR_W     = 2;   // pair index
    localparam int OUT_ELEM_W = 3;   // element fields on the result word
    localparam int TOTAL_W    = 7;   // total count on the result word
    localparam int DF_W       = 14;  // full (N-1)!! up to N = 12
    localparam int MAX_LEVELS = 4;   // levels reachable by a 2-bit pair index

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PAIR_RANGE = 2'd1,
        ST_COMB_RANGE = 2'd2
    } t_status;

    // Query word as it moves down the cell chain
    typedef struct packed {
        logic [COMB_W-1:0]     comb;    // index left for the remaining levels
        logic [PAIR_W-1:0]     pair;
        logic [OUT_ELEM_W-1:0] first;
        logic [OUT_ELEM_W-1:0] second;
        logic [TOTAL_W-1:0]    total;
        t_status               status;
    } t_item;

    // (m-1)!! over the odd factors below m; 1 for m <= 2
    function automatic logic [DF_W-1:0] odd_dfact(input logic [N_W-1:0] m);
        logic [DF_W-1:0] r;
        case (m)
            4'd0, 4'd1, 4'd2, 4'd3: r = DF_W'(1);
            4'd4, 4'd5:             r = DF_W'(3);
            4'd6, 4'd7:             r = DF_W'(15);
            4'd8, 4'd9:             r = DF_W'(105);
            4'd10, 4'd11:           r = DF_W'(945);
            4'd12:                  r = DF_W'(10395);
            default:                r = '0;  // beyond any legal set size
        endcase
        return r;
    endfunction

endpackage

>>> rtl/pmu_cell.sv
// One level of the unranking chain: extracts one mixed-radix digit,
// picks the partner element and compacts the remaining list. Uses pmu_pkg.
module pmu_cell
    import pmu_pkg::*;
#(
    parameter int MAX_ELEMENTS = 8,
    parameter int LEVEL        = 0
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic [N_W-1:0]                              i_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  t_item                                       i_item,
    input  logic [MAX_ELEMENTS-1:0][$clog2(MAX_ELEMENTS)-1:0] i_rem,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output t_item                                       o_item,
    output logic [MAX_ELEMENTS-1:0][$clog2(MAX_ELEMENTS)-1:0] o_rem
);

    localparam int ELEM_W    = $clog2(MAX_ELEMENTS);
    localparam int MAX_DIGIT = MAX_ELEMENTS - 2;
    localparam int PROD_W    = DF_W + 4;
    localparam int SEL_W     = 6;

    logic                                r_valid;
    t_item                               r_item;
    logic [MAX_ELEMENTS-1:0][ELEM_W-1:0] r_rem;
    t_item                               n_item;
    logic [MAX_ELEMENTS-1:0][ELEM_W-1:0] n_rem;

    logic              active;
    logic [N_W-1:0]    m;
    logic [DF_W-1:0]   block;
    logic [PROD_W-1:0] mult;
    logic [ELEM_W-1:0] digit;
    logic [COMB_W-1:0] comb_rem;
    logic [SEL_W-1:0]  sel_wide;
    logic [ELEM_W-1:0] sel;
    logic              take_next;

    // This level works only on good queries that reach this deep
    assign active = (i_item.status == ST_OK) && (i_item.pair >= PAIR_W'(LEVEL));

    // Digit = comb / (m-3)!!, found by comparing against all multiples
    always_comb begin
        m        = i_n - N_W'(2 * LEVEL);
        block    = odd_dfact(m - N_W'(2));
        digit    = '0;
        comb_rem = i_item.comb;
        mult     = '0;
        for (int k = 1; k <= MAX_DIGIT; k++) begin
            mult = PROD_W'(block) * PROD_W'(k);
            if (mult <= PROD_W'(i_item.comb)) begin
                digit    = ELEM_W'(k);
                comb_rem = COMB_W'(PROD_W'(i_item.comb) - mult);
            end
        end
    end

    // Partner position, clamped to the list end
    always_comb begin
        sel_wide = SEL_W'(digit) + SEL_W'(1);
        if (sel_wide >= SEL_W'(m)) begin
            sel_wide = SEL_W'(m) - SEL_W'(1);
        end
        if (sel_wide > SEL_W'(MAX_ELEMENTS - 1)) begin
            sel_wide = SEL_W'(MAX_ELEMENTS - 1);
        end
        sel = ELEM_W'(sel_wide);
    end

    // Drop the head and the partner, close up the gap
    always_comb begin
        take_next = 1'b0;
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
            take_next = SEL_W'(k + 1) < SEL_W'(sel);
            if (k + 2 < MAX_ELEMENTS) begin
                n_rem[k] = take_next ? i_rem[k + 1] : i_rem[k + 2];
            end else if (k + 1 < MAX_ELEMENTS) begin
                n_rem[k] = take_next ? i_rem[k + 1] : '0;
            end else begin
                n_rem[k] = '0;
            end
        end
    end

    // Word update for this level
    always_comb begin
        n_item = i_item;
        if (active) begin
            n_item.first  = OUT_ELEM_W'(i_rem[0]);
            n_item.second = OUT_ELEM_W'(i_rem[sel]);
            n_item.comb   = comb_rem;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
            r_rem  <= active ? n_rem : i_rem;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_rem   = r_rem;

endmodule

>>> rtl/pair_matching_unranker.sv
// Throughput: one word per cycle while the output accepts words; one check stage then one
// cell per pairing level, at most MAX_LEVELS cells.
// Each stage holds its word under output stall; bubbles close up behind a stalled output.
// Reset (synchronous, active low) clears all valid flags and sets the set size to 0.
// Top level of the pair matching unranker; uses pmu_pkg, pmu_cell and the macro header.
`include "pair_matching_unranker_macros.svh"
module pair_matching_unranker
    import pmu_pkg::*;
#(
    parameter int MAX_ELEMENTS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration: set size
    input  logic           i_cfg_we,
    input  logic [N_W-1:0] i_cfg_wdata,
    // query stream
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [15:0]    s_axis_tdata,   // combination_index[6:0], pair_index[8:7]
    // result stream
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [15:0]    m_axis_tdata,   // first_element[2:0], second_element[5:3],
                                           // total_combinations[12:6]
    output logic [1:0]     m_axis_tuser    // status[1:0]
);

    localparam int ELEM_W    = $clog2(MAX_ELEMENTS);
    localparam int NUM_CELLS = (MAX_ELEMENTS / 2 < MAX_LEVELS) ? MAX_ELEMENTS / 2
                                                               : MAX_LEVELS;

    logic [N_W-1:0] r_n;
    logic           r_front_valid;
    t_item          r_front_item;
    t_item          n_front_item;

    logic [COMB_W-1:0]     in_comb;
    logic [PAIR_W-1:0]     in_pair;
    logic                  n_ok;
    logic [N_W-2:0]        pairs;
    logic [DF_W-1:0]       total_full;

    logic                                w_valid [NUM_CELLS+1];
    logic                                w_ready [NUM_CELLS+1];
    t_item                               w_item  [NUM_CELLS+1];
    logic [MAX_ELEMENTS-1:0][ELEM_W-1:0] w_rem   [NUM_CELLS+1];

    // Set size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cfg_we) begin
            r_n <= i_cfg_wdata;
        end
    end

    assign in_comb = s_axis_tdata[COMB_W-1:0];
    assign in_pair = s_axis_tdata[COMB_W+PAIR_W-1:COMB_W];

    // Check stage: count, pair limit and range status
    always_comb begin
        n_ok       = (r_n != '0) && !r_n[0] && (r_n <= N_W'(MAX_ELEMENTS));
        pairs      = n_ok ? r_n[N_W-1:1] : '0;
        total_full = n_ok ? odd_dfact(r_n) : '0;
        n_front_item.comb   = in_comb;
        n_front_item.pair   = in_pair;
        n_front_item.first  = '0;
        n_front_item.second = '0;
        n_front_item.total  = TOTAL_W'(total_full);
        if ((N_W-1)'(in_pair) >= pairs) begin
            n_front_item.status = ST_PAIR_RANGE;
        end else if (DF_W'(in_comb) >= total_full) begin
            n_front_item.status = ST_COMB_RANGE;
        end else begin
            n_front_item.status = ST_OK;
        end
    end

    assign s_axis_tready = !r_front_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_front_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_front_item <= n_front_item;
        end
    end

    assign w_valid[0] = r_front_valid;
    assign w_item[0]  = r_front_item;

    // Fresh element list 0..MAX_ELEMENTS-1 entering the first level
    for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_init
        assign w_rem[0][k] = ELEM_W'(k);
    end

    // One cell per pairing level
    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        pmu_cell #(
            .MAX_ELEMENTS (MAX_ELEMENTS),
            .LEVEL        (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_n     (r_n),
            .i_valid (w_valid[c]),
            .o_ready (w_ready[c]),
            .i_item  (w_item[c]),
            .i_rem   (w_rem[c]),
            .o_valid (w_valid[c+1]),
            .i_ready (w_ready[c+1]),
            .o_item  (w_item[c+1]),
            .o_rem   (w_rem[c+1])
        );
    end

    // Last cell register is the output register
    assign w_ready[NUM_CELLS] = m_axis_tready;
    assign m_axis_tvalid      = w_valid[NUM_CELLS];
    assign m_axis_tdata       = {3'b000, w_item[NUM_CELLS].total,
                                 w_item[NUM_CELLS].second, w_item[NUM_CELLS].first};
    assign m_axis_tuser       = w_item[NUM_CELLS].status;

    // Error words never carry elements
    `PMU_ASSERT_SAME(a_err_no_elems, i_clk, i_rst_n, m_axis_tvalid && (w_item[NUM_CELLS].status != ST_OK), (w_item[NUM_CELLS].first == '0) && (w_item[NUM_CELLS].second == '0))
    // A good word always comes from a nonzero count
    `PMU_ASSERT_SAME(a_ok_has_total, i_clk, i_rst_n, m_axis_tvalid && (w_item[NUM_CELLS].status == ST_OK), w_item[NUM_CELLS].total != '0)
    // Check stage keeps its word while the chain is blocked
    `PMU_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, r_front_valid && !w_ready[0], r_front_valid && $stable(r_front_item))

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for pair_matching_unranker: drives query words and checks every
// result word against an in-bench unranker. Depends on pmu_pkg and the RTL top level.
module tb_top;
    import pmu_pkg::*;

    localparam int MAX_N     = 8;
    localparam int LATENCY   = 5;
    localparam int SHOW_MAX  = 10;

    // expected result word
    typedef struct packed {
        logic [2:0] first;
        logic [2:0] second;
        logic [6:0] total;
        t_status    status;
    } t_pair_answer;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [N_W-1:0] i_cfg_wdata = '0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [15:0]    s_axis_tdata = '0;   // combination_index[6:0], pair_index[8:7]
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [15:0]    m_axis_tdata;        // first[2:0], second[5:3], total[12:6]
    logic [1:0]     m_axis_tuser;        // status[1:0]

    t_pair_answer   expected_pairs[$];
    logic [N_W-1:0] checked_size = '0;   // set size as seen by the checker
    logic [N_W-1:0] drive_size = '0;     // set size as seen by the stimulus
    int             pair_mismatches = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_request = 0;
    int             hold_left = 0;

    pair_matching_unranker #(.MAX_ELEMENTS(MAX_N)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // product of the odd numbers below m
    function automatic int unsigned odd_product(input int unsigned m);
        int unsigned r;
        int unsigned k;
        r = 1;
        for (k = 1; k + 1 <= m; k += 2)
            r *= k;
        return r;
    endfunction

    // mixed-radix unranking of one pair out of one pairing
    function automatic t_pair_answer unrank_pair(input logic [N_W-1:0] n,
                                                 input logic [6:0] comb_in,
                                                 input logic [1:0] pr);
        t_pair_answer a;
        int unsigned  pairs, total, comb, m, blk, sel, k, j, lvl;
        int unsigned  rest[MAX_N];
        bit           ok;
        ok = (n != 0) && !n[0] && (n <= MAX_N);
        pairs = ok ? n / 2 : 0;
        total = ok ? odd_product(n) : 0;
        comb = comb_in;
        a.first = '0;
        a.second = '0;
        a.total = 7'(total);
        if (pr >= pairs) begin
            a.status = ST_PAIR_RANGE;
        end else if (comb >= total) begin
            a.status = ST_COMB_RANGE;
        end else begin
            a.status = ST_OK;
            for (j = 0; j < n; j++)
                rest[j] = j;
            m = n;
            for (lvl = 0; lvl <= pr && m >= 2; lvl++) begin
                blk = odd_product(m - 2);
                sel = 1 + comb / blk;
                comb = comb % blk;
                if (sel >= m)
                    sel = m - 1;
                a.first = 3'(rest[0]);
                a.second = 3'(rest[sel]);
                // drop the pair just taken, keep the rest in order
                k = 0;
                for (j = 1; j < m; j++) begin
                    if (j != sel) begin
                        rest[k] = rest[j];
                        k++;
                    end
                end
                m -= 2;
            end
        end
        return a;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // checker: predict on each accepted query, compare on each accepted result
    always @(posedge i_clk) begin
        t_pair_answer want, got;
        if (i_rst_n) begin
            if (i_cfg_we)
                checked_size = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                expected_pairs.push_back(unrank_pair(checked_size, s_axis_tdata[6:0],
                                                     s_axis_tdata[8:7]));
            if (m_axis_tvalid && m_axis_tready) begin
                got.first = m_axis_tdata[2:0];
                got.second = m_axis_tdata[5:3];
                got.total = m_axis_tdata[12:6];
                got.status = t_status'(m_axis_tuser);
                if (expected_pairs.size() == 0) begin
                    pair_mismatches++;
                    if (pair_mismatches <= SHOW_MAX)
                        $display("unexpected result word: first=%0d second=%0d total=%0d st=%0d",
                                 got.first, got.second, got.total, got.status);
                end else begin
                    want = expected_pairs.pop_front();
                    if (got !== want) begin
                        pair_mismatches++;
                        if (pair_mismatches <= SHOW_MAX)
                            $display("mismatch: exp first=%0d second=%0d total=%0d st=%0d, %s",
                                     want.first, want.second, want.total, want.status,
                                     $sformatf("got first=%0d second=%0d total=%0d st=%0d",
                                               got.first, got.second, got.total,
                                               got.status));
                    end
                end
            end
        end
    end

    // send one query word; called at a rising edge, returns at its accept edge
    task automatic send_query(input logic [6:0] comb, input logic [1:0] pr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, pr, comb};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // set size write; only while the block is idle
    task automatic write_set_size(input logic [N_W-1:0] n);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        drive_size = n;
    endtask

    // random queries, mostly in range for the current set size
    task automatic send_random(input int count);
        int unsigned total, pairs;
        logic [6:0]  comb;
        logic [1:0]  pr;
        total = ((drive_size != 0) && !drive_size[0] && (drive_size <= MAX_N))
                ? odd_product(drive_size) : 0;
        pairs = (total != 0) ? drive_size / 2 : 0;
        repeat (count) begin
            if (total != 0 && $urandom_range(9) < 8)
                comb = 7'($urandom_range(total - 1));
            else
                comb = 7'($urandom_range(127));
            if (pairs != 0 && $urandom_range(9) < 8)
                pr = 2'($urandom_range(pairs - 1));
            else
                pr = 2'($urandom_range(3));
            send_query(comb, pr);
        end
    endtask

    // set size 0 out of reset: every query reports a bad pair index
    task automatic test_reset_size();
        send_query(7'd0, 2'd0);
        send_query(7'd127, 2'd3);
        wait_drained();
    endtask

    // range edges, both indices bad, odd and oversized sets
    task automatic test_directed();
        write_set_size(4'd8);
        send_query(7'd0, 2'd0);
        send_query(7'd0, 2'd3);
        send_query(7'd104, 2'd0);
        send_query(7'd104, 2'd3);
        send_query(7'd105, 2'd0);
        send_query(7'd127, 2'd2);
        send_query(7'd52, 2'd1);
        send_query(7'd77, 2'd2);
        wait_drained();
        write_set_size(4'd2);
        send_query(7'd0, 2'd0);
        send_query(7'd1, 2'd0);
        send_query(7'd0, 2'd1);
        send_query(7'd127, 2'd3);
        wait_drained();
        write_set_size(4'd7);
        send_query(7'd0, 2'd0);
        send_query(7'd3, 2'd1);
        wait_drained();
        write_set_size(4'd15);
        send_query(7'd127, 2'd3);
        send_query(7'd5, 2'd0);
        wait_drained();
        write_set_size(4'd4);
        send_query(7'd2, 2'd1);
        send_query(7'd3, 2'd1);
        wait_drained();
        write_set_size(4'd6);
        send_query(7'd14, 2'd2);
        send_query(7'd15, 2'd2);
        wait_drained();
        write_set_size(4'd0);
        send_query(7'd0, 2'd0);
        wait_drained();
    endtask

    // random queries over several set sizes and idle patterns
    task automatic test_random_queries();
        int sizes[10] = '{8, 2, 4, 6, 8, 1, 8, 10, 6, 15};
        int send_pct[4] = '{0, 82, 0, 23};
        int recv_pct[4] = '{0, 0, 82, 23};
        for (int s = 0; s < 10; s++) begin
            send_idle_pct = send_pct[s % 4];
            recv_stall_pct = recv_pct[s % 4];
            write_set_size(4'(sizes[s]));
            send_random(180);
            wait_drained();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // long receiver hold-off while the sender keeps offering words
    task automatic test_output_stall();
        write_set_size(4'd8);
        hold_request = 300;
        send_random(40);
        wait_drained();
    endtask

    // sender pauses until the pipeline is empty, then resumes
    task automatic test_pause_resume();
        write_set_size(4'd6);
        recv_stall_pct = 23;
        send_random(20);
        wait_drained();
        send_random(20);
        wait_drained();
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_size();
        test_directed();
        test_random_queries();
        test_output_stall();
        test_pause_resume();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (pair_mismatches == 0 && expected_pairs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
